// ===== rtl/msns_pkg.sv =====
// ----------------------------------------------------------------------------
// msns_pkg: shared types, constants and tables of the note sequencer
// Scale, accent and Markov weight tables, command codes, field widths.
// ----------------------------------------------------------------------------
`default_nettype none
package msns_pkg;

   localparam int PHRASE_NOTES_DEFAULT = 32;

   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_STOP  = 2'd2;

   localparam logic [1:0] REG_SCALE  = 2'd0;
   localparam logic [1:0] REG_RHYTHM = 2'd1;
   localparam logic [1:0] REG_ROOT   = 2'd2;
   localparam logic [1:0] REG_TEMPO  = 2'd3;

   localparam logic [15:0] BPM_MIN     = 16'd40;
   localparam logic [15:0] BPM_MAX     = 16'd240;
   localparam logic [15:0] TICKS_PER_MIN = 16'd60000;
   localparam logic [10:0] INTERVAL_MIN  = 11'd40;
   localparam logic [10:0] DURATION_MIN  = 11'd30;
   localparam logic [6:0]  VEL_BASE      = 7'd100;

   // Job handed from the sequencer to the divider.
   typedef struct packed {
      logic        start;
      logic [15:0] dividend;
      logic [7:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [15:0] quotient;
   } div_rsp_type;

   function automatic logic [3:0] scale_interval(input logic [2:0] sel,
                                                 input logic [2:0] deg);
      logic [3:0] t [8][7];
      t[0] = '{4'd0, 4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10};
      t[1] = '{4'd0, 4'd1, 4'd4, 4'd5, 4'd6, 4'd9, 4'd11};
      t[2] = '{4'd0, 4'd2, 4'd4, 4'd7, 4'd9, 4'd0, 4'd0};
      t[3] = '{4'd0, 4'd1, 4'd3, 4'd6, 4'd7, 4'd8, 4'd11};
      t[4] = '{4'd0, 4'd2, 4'd3, 4'd6, 4'd7, 4'd9, 4'd11};
      t[5] = '{4'd0, 4'd2, 4'd5, 4'd7, 4'd10, 4'd0, 4'd0};
      t[6] = '{4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11};
      t[7] = '{4'd0, 4'd3, 4'd5, 4'd8, 4'd10, 4'd0, 4'd0};
      return (deg == 3'd7) ? t[sel][0] : t[sel][deg];
   endfunction

   function automatic logic [2:0] scale_length(input logic [2:0] sel);
      return (sel == 3'd2 || sel == 3'd5 || sel == 3'd7) ? 3'd5 : 3'd7;
   endfunction

   // Accent 0..2 of a beat; 16-beat cycle is the default.
   function automatic logic [1:0] accent(input logic [1:0] rhythm,
                                         input logic [3:0] beat);
      logic [1:0] a;
      a = 2'd0;
      case (rhythm)
         2'd1: begin
            if (beat == 4'd0) a = 2'd2;
            else if (beat == 4'd3) a = 2'd1;
         end
         2'd2: begin
            if (beat == 4'd0) a = 2'd2;
            else if (beat == 4'd3 || beat == 4'd7) a = 2'd1;
         end
         default: begin
            if (beat == 4'd0) a = 2'd2;
            else if (beat[1:0] == 2'd0) a = 2'd1;
         end
      endcase
      return a;
   endfunction

   function automatic logic [6:0] markov_weight(input logic [2:0] older,
                                                input logic [2:0] newer,
                                                input logic [2:0] idx);
      logic [6:0] w [7][7][7];
      w[0][0] = '{7'd40,7'd30,7'd15,7'd25,7'd10,7'd5,7'd5};
      w[0][1] = '{7'd20,7'd20,7'd40,7'd35,7'd10,7'd5,7'd5};
      w[0][2] = '{7'd15,7'd25,7'd20,7'd50,7'd10,7'd5,7'd5};
      w[0][3] = '{7'd30,7'd20,7'd30,7'd30,7'd15,7'd10,7'd5};
      w[0][4] = '{7'd25,7'd15,7'd20,7'd40,7'd20,7'd15,7'd10};
      w[0][5] = '{7'd20,7'd15,7'd10,7'd25,7'd15,7'd20,7'd30};
      w[0][6] = '{7'd50,7'd20,7'd10,7'd15,7'd10,7'd10,7'd15};
      w[1][0] = '{7'd40,7'd30,7'd20,7'd20,7'd10,7'd5,7'd5};
      w[1][1] = '{7'd25,7'd35,7'd30,7'd20,7'd10,7'd5,7'd5};
      w[1][2] = '{7'd15,7'd20,7'd25,7'd45,7'd15,7'd5,7'd5};
      w[1][3] = '{7'd25,7'd20,7'd35,7'd30,7'd15,7'd10,7'd5};
      w[1][4] = '{7'd20,7'd25,7'd20,7'd35,7'd20,7'd10,7'd5};
      w[1][5] = '{7'd15,7'd20,7'd15,7'd25,7'd15,7'd25,7'd20};
      w[1][6] = '{7'd45,7'd25,7'd15,7'd15,7'd10,7'd10,7'd10};
      w[2][0] = '{7'd35,7'd30,7'd20,7'd25,7'd10,7'd5,7'd5};
      w[2][1] = '{7'd35,7'd25,7'd25,7'd25,7'd10,7'd5,7'd5};
      w[2][2] = '{7'd20,7'd25,7'd25,7'd35,7'd15,7'd10,7'd5};
      w[2][3] = '{7'd20,7'd15,7'd20,7'd40,7'd20,7'd20,7'd10};
      w[2][4] = '{7'd15,7'd20,7'd25,7'd40,7'd20,7'd15,7'd10};
      w[2][5] = '{7'd10,7'd15,7'd15,7'd30,7'd15,7'd25,7'd25};
      w[2][6] = '{7'd40,7'd25,7'd15,7'd15,7'd10,7'd10,7'd15};
      w[3][0] = '{7'd45,7'd30,7'd20,7'd20,7'd10,7'd5,7'd5};
      w[3][1] = '{7'd30,7'd25,7'd30,7'd25,7'd10,7'd5,7'd5};
      w[3][2] = '{7'd25,7'd35,7'd25,7'd25,7'd10,7'd5,7'd5};
      w[3][3] = '{7'd25,7'd20,7'd25,7'd40,7'd20,7'd15,7'd10};
      w[3][4] = '{7'd20,7'd15,7'd20,7'd40,7'd25,7'd15,7'd10};
      w[3][5] = '{7'd10,7'd10,7'd15,7'd30,7'd15,7'd25,7'd35};
      w[3][6] = '{7'd50,7'd20,7'd15,7'd20,7'd10,7'd10,7'd10};
      w[4][0] = '{7'd40,7'd25,7'd20,7'd25,7'd15,7'd5,7'd5};
      w[4][1] = '{7'd25,7'd25,7'd25,7'd30,7'd15,7'd10,7'd5};
      w[4][2] = '{7'd20,7'd25,7'd25,7'd40,7'd15,7'd10,7'd5};
      w[4][3] = '{7'd20,7'd20,7'd25,7'd40,7'd20,7'd15,7'd10};
      w[4][4] = '{7'd25,7'd15,7'd20,7'd40,7'd25,7'd20,7'd10};
      w[4][5] = '{7'd15,7'd15,7'd15,7'd30,7'd15,7'd30,7'd25};
      w[4][6] = '{7'd45,7'd20,7'd15,7'd20,7'd15,7'd10,7'd10};
      w[5][0] = '{7'd40,7'd25,7'd20,7'd20,7'd15,7'd10,7'd10};
      w[5][1] = '{7'd25,7'd30,7'd25,7'd25,7'd15,7'd15,7'd10};
      w[5][2] = '{7'd20,7'd25,7'd25,7'd35,7'd15,7'd15,7'd10};
      w[5][3] = '{7'd20,7'd20,7'd25,7'd35,7'd20,7'd20,7'd15};
      w[5][4] = '{7'd20,7'd20,7'd20,7'd35,7'd25,7'd20,7'd15};
      w[5][5] = '{7'd15,7'd15,7'd15,7'd25,7'd15,7'd30,7'd30};
      w[5][6] = '{7'd45,7'd20,7'd15,7'd20,7'd15,7'd15,7'd15};
      w[6][0] = '{7'd50,7'd25,7'd15,7'd20,7'd10,7'd10,7'd10};
      w[6][1] = '{7'd30,7'd30,7'd25,7'd25,7'd15,7'd10,7'd5};
      w[6][2] = '{7'd25,7'd25,7'd25,7'd30,7'd15,7'd10,7'd10};
      w[6][3] = '{7'd25,7'd20,7'd25,7'd35,7'd15,7'd15,7'd10};
      w[6][4] = '{7'd25,7'd20,7'd20,7'd35,7'd20,7'd15,7'd10};
      w[6][5] = '{7'd20,7'd20,7'd15,7'd25,7'd15,7'd25,7'd25};
      w[6][6] = '{7'd45,7'd25,7'd15,7'd20,7'd10,7'd10,7'd15};
      return w[older][newer][idx];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/msns_divider.sv =====
// ----------------------------------------------------------------------------
// msns_divider: restoring divider, one quotient bit per cycle
// Divides a 16-bit dividend by an 8-bit divisor.
// ----------------------------------------------------------------------------
`default_nettype none
module msns_divider (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire msns_pkg::div_req_type req,
   output msns_pkg::div_rsp_type      rsp
);
   logic [15:0] quot_ff, quot_in;
   logic [8:0]  rem_ff, rem_in;
   logic [7:0]  dvs_ff, dvs_in;
   logic [4:0]  count_ff, count_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [8:0]  trial;

   always_comb begin
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      trial    = {rem_ff[7:0], quot_ff[15]};
      if (req.start) begin
         quot_in  = req.dividend;
         rem_in   = '0;
         dvs_in   = req.divisor;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         // shift in next dividend bit, subtract when it fits
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in  = trial - {1'b0, dvs_ff};
            quot_in = {quot_ff[14:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[14:0], 1'b0};
         end
         count_in = count_ff + 5'd1;
         if (count_ff == 5'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
      count_ff <= count_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quot_ff;
endmodule
`default_nettype wire

// ===== rtl/markov_scale_note_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// markov_scale_note_sequencer_core: generative note sequencer
// Tick-driven note on / note off generator with Markov or walk melody.
// ----------------------------------------------------------------------------
// One input word is taken at a time. A start, stop, unknown command or a tick
// while stopped passes through the decode, note-off and finish states before
// the next word can be taken. A tick while playing always divides 60000 by the
// clamped bpm in a one-bit-per-cycle divider, whose quotient over four, floored
// at 40, is the note interval. A tick that plays a note goes on to pick a
// degree: by a walk step on a walk scale, or on the Markov scale by weights
// accumulated one per cycle (up to 7). Up to two result words (note off, note
// on) leave through a one-word output register, and the note-off and note-on
// states stall while a result word waits for the receiver.
`default_nettype none
module markov_scale_note_sequencer_core #(
   parameter int PHRASE_NOTES = msns_pkg::PHRASE_NOTES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [1:0] cmd, [9:2] rand_pick, [11:10] rand_step, [18:12] rand_chance,
   // [20:19] rand_shift, [23:21] rand_start
   input  wire logic [23:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] note_number, [14:8] velocity, [18:15] beat_index, rest zero
   output logic [23:0]      rsp_tdata,
   // [0] event_kind
   output logic             rsp_tuser,
   output logic             rsp_tlast,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   localparam int PW = $clog2(PHRASE_NOTES + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECODE, ST_DIV, ST_PICK, ST_NOTE, ST_OFF, ST_ON, ST_FINISH
   } state_type;

   state_type   state_ff;
   logic [2:0]  scale_ff;
   logic [1:0]  rhythm_ff;
   logic [6:0]  root_ff;
   logic [15:0] tempo_ff;

   logic [1:0]  cmd_ff;
   logic [7:0]  pick_ff;
   logic [1:0]  step_ff, shift_ff;
   logic [6:0]  chance_ff;
   logic [2:0]  start_ff;

   logic [31:0] time_ff, last_ff, off_time_ff;
   logic        first_ff, playing_ff, sounding_ff;
   logic [7:0]  snote_ff;
   logic [3:0]  beat_ff;
   logic [PW-1:0] phrase_ff;
   logic [2:0]  older_ff, newer_ff, walk_ff;
   logic [1:0]  oct_ff;       // 0,1,2 = -1,0,+1
   logic [10:0] interval_ff;
   logic [2:0]  idx_ff, deg_ff;
   logic [8:0]  cum_ff;
   logic        want_off_ff, want_on_ff;
   logic [7:0]  on_note_ff;

   logic        out_valid_ff, out_kind_ff, out_last_ff;
   logic [7:0]  out_note_ff;
   logic [6:0]  out_vel_ff;
   logic [3:0]  out_beat_ff;

   msns_pkg::div_req_type div_req;
   msns_pkg::div_rsp_type div_rsp;

   msns_divider u_div (.clock(clock), .reset(reset), .req(div_req), .rsp(div_rsp));

   logic [15:0] bpm_c;
   always_comb begin
      bpm_c = tempo_ff;
      if (tempo_ff < msns_pkg::BPM_MIN) bpm_c = msns_pkg::BPM_MIN;
      if (tempo_ff > msns_pkg::BPM_MAX) bpm_c = msns_pkg::BPM_MAX;
   end
   assign div_req.dividend = msns_pkg::TICKS_PER_MIN;
   assign div_req.divisor  = bpm_c[7:0];
   assign div_req.start    = (state_ff == ST_DECODE);

   // quotient/4, floored at 40; max 375 fits 11 bits
   logic [10:0] iv_raw, iv_c;
   assign iv_raw = div_rsp.quotient[12:2];
   assign iv_c   = (iv_raw < msns_pkg::INTERVAL_MIN) ? msns_pkg::INTERVAL_MIN : iv_raw;

   // duration = interval*8/10 = interval*4/5, by reciprocal 13108/2^16
   logic [24:0] dur_prod;
   logic [10:0] dur_raw, dur_c;
   assign dur_prod = {interval_ff, 2'b00} * 25'd13108;
   assign dur_raw  = {2'b0, dur_prod[24:16]};
   assign dur_c    = (dur_raw < msns_pkg::DURATION_MIN) ? msns_pkg::DURATION_MIN : dur_raw;

   logic [2:0] len_c;
   assign len_c = msns_pkg::scale_length(scale_ff);
   logic       new_phrase;
   assign new_phrase = phrase_ff >= PW'(PHRASE_NOTES);
   logic [2:0] hist_old, hist_new, walk_base;
   assign hist_old  = new_phrase ? 3'd0 : older_ff;
   assign hist_new  = new_phrase ? 3'd0 : newer_ff;
   assign walk_base = new_phrase ? ((start_ff > len_c - 3'd1) ? len_c - 3'd1 : start_ff)
                                 : walk_ff;
   logic [8:0] cum_next;
   assign cum_next = cum_ff + {2'b0, msns_pkg::markov_weight(hist_old, hist_new, idx_ff)};

   logic [1:0] step_c, shift_c;
   assign step_c  = (step_ff > 2'd2) ? 2'd2 : step_ff;
   assign shift_c = (shift_ff > 2'd2) ? 2'd2 : shift_ff;

   logic [3:0] beats_c, beat_c;
   logic [6:0] vel_c;
   always_comb begin
      case (rhythm_ff)
         2'd1:    beats_c = 4'd7;
         2'd2:    beats_c = 4'd10;
         default: beats_c = 4'd0; // sixteen, wraps naturally
      endcase
      beat_c = (beats_c != 4'd0 && beat_ff >= beats_c) ? 4'd0 : beat_ff;
      vel_c  = msns_pkg::VEL_BASE + {2'b0, msns_pkg::accent(rhythm_ff, beat_c), 3'b000};
   end

   logic [31:0] since;
   assign since = time_ff - last_ff;
   logic        out_free;
   assign out_free = !out_valid_ff || rsp_tready;
   logic        load_out;
   assign load_out = out_free && ((state_ff == ST_OFF && want_off_ff) || state_ff == ST_ON);
   logic        wr;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         scale_ff <= '0; rhythm_ff <= '0; root_ff <= 7'd60; tempo_ff <= 16'd120;
         time_ff <= '0; last_ff <= '0; off_time_ff <= '0;
         first_ff <= 1'b1; playing_ff <= 1'b0; sounding_ff <= 1'b0;
         snote_ff <= '0; beat_ff <= '0; phrase_ff <= PW'(PHRASE_NOTES);
         older_ff <= '0; newer_ff <= '0; walk_ff <= '0; oct_ff <= 2'd1;
         out_valid_ff <= 1'b0;
         want_off_ff <= 1'b0; want_on_ff <= 1'b0;
      end else begin
         if (wr) begin
            unique case (csr_paddr[3:2])
               msns_pkg::REG_SCALE:  scale_ff  <= csr_pwdata[2:0];
               msns_pkg::REG_RHYTHM: rhythm_ff <= csr_pwdata[1:0];
               msns_pkg::REG_ROOT:   root_ff   <= csr_pwdata[6:0];
               msns_pkg::REG_TEMPO:  tempo_ff  <= csr_pwdata[15:0];
               default: ;
            endcase
         end
         if (out_valid_ff && rsp_tready && !load_out) out_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  cmd_ff    <= req_tdata[1:0];
                  pick_ff   <= req_tdata[9:2];
                  step_ff   <= req_tdata[11:10];
                  chance_ff <= req_tdata[18:12];
                  shift_ff  <= req_tdata[20:19];
                  start_ff  <= req_tdata[23:21];
                  state_ff  <= ST_DECODE;
               end
            end
            ST_DECODE: begin
               want_on_ff <= 1'b0;
               unique case (cmd_ff)
                  msns_pkg::CMD_START: begin
                     want_off_ff <= sounding_ff;
                     phrase_ff   <= PW'(PHRASE_NOTES);
                     beat_ff     <= '0;
                     off_time_ff <= '0;
                     first_ff    <= 1'b1;
                     playing_ff  <= 1'b1;
                     state_ff    <= ST_OFF;
                  end
                  msns_pkg::CMD_STOP: begin
                     want_off_ff <= sounding_ff;
                     playing_ff  <= 1'b0;
                     off_time_ff <= '0;
                     state_ff    <= ST_OFF;
                  end
                  msns_pkg::CMD_TICK: begin
                     want_off_ff <= 1'b0;
                     time_ff     <= time_ff + 32'd1;
                     state_ff    <= playing_ff ? ST_DIV : ST_OFF;
                  end
                  default: begin
                     want_off_ff <= 1'b0;
                     state_ff    <= ST_OFF;
                  end
               endcase
            end
            ST_DIV: begin
               // time_ff already advanced here
               if (div_rsp.done) begin
                  interval_ff <= iv_c;
                  if (first_ff || since >= {21'd0, iv_c}) begin
                     idx_ff   <= '0;
                     cum_ff   <= '0;
                     deg_ff   <= '0;
                     state_ff <= (scale_ff == 3'd0) ? ST_PICK : ST_NOTE;
                  end else begin
                     want_off_ff <= sounding_ff && (time_ff >= off_time_ff);
                     state_ff    <= ST_OFF;
                  end
               end
            end
            ST_PICK: begin
               // one weight per cycle; no hit leaves degree 0
               cum_ff <= cum_next;
               idx_ff <= idx_ff + 3'd1;
               if ({1'b0, pick_ff} < cum_next) begin
                  deg_ff   <= idx_ff;
                  state_ff <= ST_NOTE;
               end else if (idx_ff == 3'd6) begin
                  state_ff <= ST_NOTE;
               end
            end
            ST_NOTE: begin : note_blk
               logic [2:0] deg;
               logic [3:0] wsum;
               logic [2:0] oct_base, onext;
               logic [7:0] nnote;
               if (scale_ff == 3'd0) begin
                  deg      = deg_ff;
                  older_ff <= hist_new;
                  newer_ff <= deg_ff;
                  // a new phrase still restarts the walk
                  if (new_phrase) walk_ff <= walk_base;
               end else begin
                  wsum = {1'b0, walk_base} + {2'b0, step_c};
                  if (wsum == 4'd0) deg = 3'd0;
                  else if (wsum - 4'd1 > {1'b0, len_c - 3'd1}) deg = len_c - 3'd1;
                  else deg = 3'(wsum - 4'd1);
                  walk_ff <= deg;
                  if (new_phrase) begin older_ff <= 3'd0; newer_ff <= 3'd0; end
               end
               oct_base = new_phrase ? 3'd1 : {1'b0, oct_ff};
               onext    = oct_base;
               if (chance_ff < ((scale_ff == 3'd0) ? 7'd8 : 7'd10)) begin
                  onext = oct_base + {1'b0, shift_c};
                  onext = (onext == 3'd0) ? 3'd0 : onext - 3'd1;
                  if (onext > 3'd2) onext = 3'd2;
               end
               oct_ff <= onext[1:0];
               nnote = {1'b0, root_ff} + {4'b0, msns_pkg::scale_interval(scale_ff, deg)}
                       + ((onext == 3'd2) ? 8'd12 : (onext == 3'd0) ? 8'd244 : 8'd0);
               on_note_ff  <= nnote;
               phrase_ff   <= (new_phrase ? PW'(0) : phrase_ff) + PW'(1);
               want_off_ff <= sounding_ff;
               want_on_ff  <= 1'b1;
               last_ff     <= time_ff;
               first_ff    <= 1'b0;
               state_ff    <= ST_OFF;
            end
            ST_OFF: begin
               if (!want_off_ff) begin
                  state_ff <= want_on_ff ? ST_ON : ST_FINISH;
               end else if (out_free) begin
                  out_valid_ff <= 1'b1;
                  out_kind_ff  <= 1'b0;
                  out_note_ff  <= snote_ff;
                  out_vel_ff   <= '0;
                  out_beat_ff  <= '0;
                  out_last_ff  <= !want_on_ff;
                  sounding_ff  <= 1'b0;
                  want_off_ff  <= 1'b0;
                  state_ff     <= want_on_ff ? ST_ON : ST_FINISH;
               end
            end
            ST_ON: begin
               if (out_free) begin
                  out_valid_ff <= 1'b1;
                  out_kind_ff  <= 1'b1;
                  out_note_ff  <= on_note_ff;
                  out_vel_ff   <= vel_c;
                  out_beat_ff  <= beat_c;
                  out_last_ff  <= 1'b1;
                  snote_ff     <= on_note_ff;
                  sounding_ff  <= 1'b1;
                  off_time_ff  <= time_ff + {21'd0, dur_c};
                  beat_ff      <= (beats_c != 4'd0 && beat_c + 4'd1 == beats_c) ? 4'd0
                                                                        : beat_c + 4'd1;
                  want_on_ff   <= 1'b0;
                  state_ff     <= ST_FINISH;
               end
            end
            ST_FINISH: state_ff <= ST_IDLE;
            default:   state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_beat_ff, out_vel_ff, out_note_ff};
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
   assign csr_pready = 1'b1;

   always_comb begin
      csr_prdata = '0;
      unique case (csr_paddr[3:2])
         msns_pkg::REG_SCALE:  csr_prdata = {29'd0, scale_ff};
         msns_pkg::REG_RHYTHM: csr_prdata = {30'd0, rhythm_ff};
         msns_pkg::REG_ROOT:   csr_prdata = {25'd0, root_ff};
         msns_pkg::REG_TEMPO:  csr_prdata = {16'd0, tempo_ff};
         default:              csr_prdata = '0;
      endcase
   end
endmodule
`default_nettype wire

// ===== rtl/msns_checker.sv =====
// ----------------------------------------------------------------------------
// msns_checker: port-level checks of the note sequencer
// Watches the stream and register ports over time.
// ----------------------------------------------------------------------------
`default_nettype none
module msns_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic        rsp_tuser,
   input wire logic        csr_pready
);
   // a note off never carries velocity
   a_off_vel: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[14:8] == 7'd0)
      else $error("note off with velocity");
   // a note on carries one of the accent velocities
   a_on_vel: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[14:8] == 7'd100 ||
         rsp_tdata[14:8] == 7'd108 || rsp_tdata[14:8] == 7'd116)
      else $error("bad note on velocity");
   // one word at a time: no new word right after acceptance
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after accept");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled word changed");
   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("pready low");
endmodule

bind markov_scale_note_sequencer_core msns_checker u_msns_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser), .csr_pready(csr_pready)
);
`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the generative note sequencer
// Streams tick, start, stop and unknown words with random draws, predicts every
// note on and note off, and compares the result stream while both sides stall.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CMD_NONE = 2'd3;
   localparam bit KIND_OFF = 1'b0;
   localparam bit KIND_ON  = 1'b1;
   localparam int PHRASE_LEN = msns_pkg::PHRASE_NOTES_DEFAULT;
   localparam int DRAIN_CYCLES = 64;
   localparam int CYCLE_LIMIT = 1500000;

   localparam bit [3:0] SCALE_TAB [8][7] = '{
      '{0, 1, 3, 5, 7, 8, 10}, '{0, 1, 4, 5, 6, 9, 11}, '{0, 2, 4, 7, 9, 0, 0},
      '{0, 1, 3, 6, 7, 8, 11}, '{0, 2, 3, 6, 7, 9, 11}, '{0, 2, 5, 7, 10, 0, 0},
      '{0, 2, 4, 6, 7, 9, 11}, '{0, 3, 5, 8, 10, 0, 0}};
   localparam int SCALE_LEN [8] = '{7, 7, 5, 7, 7, 5, 7, 5};
   localparam bit [1:0] ACC16 [16] = '{2,0,0,0,1,0,0,0,1,0,0,0,1,0,0,0};
   localparam bit [1:0] ACC7 [7] = '{2,0,0,1,0,0,0};
   localparam bit [1:0] ACC10 [10] = '{2,0,0,1,0,0,0,1,0,0};

   localparam bit [6:0] MARKOV_W [7][7][7] = '{
      '{'{40,30,15,25,10,5,5}, '{20,20,40,35,10,5,5}, '{15,25,20,50,10,5,5},
        '{30,20,30,30,15,10,5}, '{25,15,20,40,20,15,10}, '{20,15,10,25,15,20,30},
        '{50,20,10,15,10,10,15}},
      '{'{40,30,20,20,10,5,5}, '{25,35,30,20,10,5,5}, '{15,20,25,45,15,5,5},
        '{25,20,35,30,15,10,5}, '{20,25,20,35,20,10,5}, '{15,20,15,25,15,25,20},
        '{45,25,15,15,10,10,10}},
      '{'{35,30,20,25,10,5,5}, '{35,25,25,25,10,5,5}, '{20,25,25,35,15,10,5},
        '{20,15,20,40,20,20,10}, '{15,20,25,40,20,15,10}, '{10,15,15,30,15,25,25},
        '{40,25,15,15,10,10,15}},
      '{'{45,30,20,20,10,5,5}, '{30,25,30,25,10,5,5}, '{25,35,25,25,10,5,5},
        '{25,20,25,40,20,15,10}, '{20,15,20,40,25,15,10}, '{10,10,15,30,15,25,35},
        '{50,20,15,20,10,10,10}},
      '{'{40,25,20,25,15,5,5}, '{25,25,25,30,15,10,5}, '{20,25,25,40,15,10,5},
        '{20,20,25,40,20,15,10}, '{25,15,20,40,25,20,10}, '{15,15,15,30,15,30,25},
        '{45,20,15,20,15,10,10}},
      '{'{40,25,20,20,15,10,10}, '{25,30,25,25,15,15,10}, '{20,25,25,35,15,15,10},
        '{20,20,25,35,20,20,15}, '{20,20,20,35,25,20,15}, '{15,15,15,25,15,30,30},
        '{45,20,15,20,15,15,15}},
      '{'{50,25,15,20,10,10,10}, '{30,30,25,25,15,10,5}, '{25,25,25,30,15,10,10},
        '{25,20,25,35,15,15,10}, '{25,20,20,35,20,15,10}, '{20,20,15,25,15,25,25},
        '{45,25,15,20,10,10,15}}};

   typedef struct {
      bit       kind;
      bit [7:0] note;
      bit [6:0] vel;
      bit [3:0] beat;
      bit       last;
   } note_event_t;

   class note_scoreboard;
      note_event_t expected_q[$];
      int errors;
      bit [2:0] scale_sel;
      bit [1:0] rhythm_sel;
      bit [6:0] root;
      bit [15:0] bpm;
      bit [31:0] t_now, t_last_note, t_off;
      bit first_due, playing, sounding;
      bit [7:0] held_note;
      int beat_pos, phrase_pos, older, newer, walk, octave;

      function new();
         errors = 0;
         scale_sel = 0; rhythm_sel = 0; root = 60; bpm = 120;
         t_now = 0; t_last_note = 0; t_off = 0;
         first_due = 1; playing = 0; sounding = 0; held_note = 0;
         beat_pos = 0; phrase_pos = PHRASE_LEN;
         older = 0; newer = 0; walk = 0; octave = 0;
      endfunction

      function void write_reg(logic [1:0] idx, bit [31:0] v);
         case (idx)
            msns_pkg::REG_SCALE:  scale_sel = v[2:0];
            msns_pkg::REG_RHYTHM: rhythm_sel = v[1:0];
            msns_pkg::REG_ROOT:   root = v[6:0];
            default:              bpm = v[15:0];
         endcase
      endfunction

      function int unsigned note_interval();
         int unsigned b, iv;
         b = bpm;
         if (b < 40) b = 40;
         if (b > 240) b = 240;
         iv = (60000 / b) / 4;
         return (iv < 40) ? 40 : iv;
      endfunction

      function void push_event(bit kind, bit [7:0] note, bit [6:0] vel, bit [3:0] beat);
         note_event_t e;
         e.kind = kind; e.note = note; e.vel = vel; e.beat = beat; e.last = 0;
         expected_q.push_back(e);
      endfunction

      function void release_note();
         if (sounding) begin
            push_event(KIND_OFF, held_note, 7'd0, 4'd0);
            sounding = 0;
         end
      endfunction

      function void play_note(bit [23:0] w);
         int len, deg, step, shift, limit, beats, beat, acc, cum, d, o;
         int unsigned dur;
         bit [7:0] note;
         len = SCALE_LEN[scale_sel];
         limit = (scale_sel == 0) ? 8 : 10;
         step = (w[11:10] > 2) ? 2 : w[11:10];
         shift = (w[20:19] > 2) ? 2 : w[20:19];
         if (phrase_pos >= PHRASE_LEN) begin
            older = 0; newer = 0; octave = 0;
            walk = (w[23:21] > len - 1) ? len - 1 : w[23:21];
            phrase_pos = 0;
         end
         if (scale_sel == 0) begin
            deg = 0;
            cum = 0;
            for (int i = 0; i < 7; i++) begin
               cum += MARKOV_W[older][newer][i];
               if (w[9:2] < cum) begin
                  deg = i;
                  break;
               end
            end
            older = newer;
            newer = deg;
         end else begin
            d = walk + step - 1;
            if (d < 0) d = 0;
            if (d > len - 1) d = len - 1;
            walk = d;
            deg = d;
         end
         if (w[18:12] < limit) begin
            o = octave + shift - 1;
            if (o < -1) o = -1;
            if (o > 1) o = 1;
            octave = o;
         end
         phrase_pos++;
         release_note();
         beats = (rhythm_sel == 1) ? 7 : (rhythm_sel == 2) ? 10 : 16;
         beat = (beat_pos < beats) ? beat_pos : 0;
         acc = (beats == 7) ? ACC7[beat] : (beats == 10) ? ACC10[beat] : ACC16[beat];
         note = 8'(int'(root) + int'(SCALE_TAB[scale_sel][deg]) + octave * 12);
         push_event(KIND_ON, note, 7'(100 + acc * 8), 4'(beat));
         held_note = note;
         sounding = 1;
         dur = note_interval() * 8 / 10;
         if (dur < 30) dur = 30;
         t_off = t_now + dur;
         beat_pos = (beat + 1) % beats;
      endfunction

      function void note_input(bit [23:0] w);
         int before_n;
         before_n = expected_q.size();
         case (w[1:0])
            msns_pkg::CMD_START: begin
               release_note();
               phrase_pos = PHRASE_LEN;
               beat_pos = 0;
               t_off = 0;
               first_due = 1;
               playing = 1;
            end
            msns_pkg::CMD_STOP: begin
               release_note();
               playing = 0;
               t_off = 0;
            end
            msns_pkg::CMD_TICK: begin
               t_now++;
               if (playing) begin
                  if (first_due || (t_now - t_last_note) >= note_interval()) begin
                     play_note(w);
                     t_last_note = t_now;
                     first_due = 0;
                  end else if (sounding && t_now >= t_off) begin
                     release_note();
                  end
               end
            end
            default: ;
         endcase
         if (expected_q.size() > before_n) expected_q[$].last = 1;
      endfunction

      function void check_result(bit kind, bit [7:0] note, bit [6:0] vel, bit [3:0] beat,
                                 bit last);
         note_event_t e;
         if (expected_q.size() == 0) begin
            $error("unexpected result word: kind %0d note %0d", kind, note);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (kind != e.kind) begin
            $error("event_kind: expected %0d, got %0d", e.kind, kind); errors++;
         end
         if (note != e.note) begin
            $error("note_number: expected %0d, got %0d", e.note, note); errors++;
         end
         if (vel != e.vel) begin
            $error("velocity: expected %0d, got %0d", e.vel, vel); errors++;
         end
         if (beat != e.beat) begin
            $error("beat_index: expected %0d, got %0d", e.beat, beat); errors++;
         end
         if (last != e.last) begin
            $error("last_event: expected %0d, got %0d", e.last, last); errors++;
         end
      endfunction
   endclass

   logic        clock, reset;
   logic        req_tvalid, req_tready;
   logic [23:0] req_tdata;
   logic        rsp_tvalid, rsp_tready;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser, rsp_tlast;
   logic        csr_psel, csr_penable, csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic        csr_pready;

   note_scoreboard sb;
   int  cycles = 0;
   int  results_seen = 0;
   bit  hold_request = 0;
   bit  send_burst = 0;

   markov_scale_note_sequencer_core u_top (.*);

   always begin
      clock = 1'b1; #10;
      clock = 1'b0; #10;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // compare every accepted result word
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tuser, rsp_tdata[7:0], rsp_tdata[14:8], rsp_tdata[18:15],
                         rsp_tlast);
         results_seen++;
      end
   end

   // receiver: random stalls, burst stretches and one long hold-off
   initial begin : receiver
      int gap;
      bit burst;
      burst = 0;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_tready = 1'b0;
            repeat (400) @(negedge clock);
            hold_request = 0;
         end
         if ($urandom_range(0, 39) == 0) burst = !burst;
         gap = burst ? 0 : $urandom_range(0, 11);
         if (gap > 0) begin
            rsp_tready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         @(negedge clock);
      end
   end

   task automatic write_reg(logic [1:0] idx, bit [31:0] v);
      csr_psel = 1'b1; csr_pwrite = 1'b1; csr_penable = 1'b0;
      csr_paddr = {idx, 2'b00}; csr_pwdata = v;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      sb.write_reg(idx, v);
   endtask

   task automatic send_word(bit [23:0] w);
      int gap;
      if ($urandom_range(0, 59) == 0) send_burst = !send_burst;
      gap = send_burst ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata = w;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_input(w);
      @(negedge clock);
      // drop the word once taken; the next call raises valid again
      req_tvalid = 1'b0;
   endtask

   function automatic bit [23:0] make_word(logic [1:0] cmd);
      bit [23:0] w;
      w[1:0] = cmd;
      w[9:2] = 8'($urandom_range(0, 255));
      w[11:10] = 2'($urandom_range(0, 3));
      w[18:12] = ($urandom_range(0, 1) != 0) ? 7'($urandom_range(0, 15))
                                             : 7'($urandom_range(0, 127));
      w[20:19] = 2'($urandom_range(0, 3));
      w[23:21] = 3'($urandom_range(0, 7));
      return w;
   endfunction

   function automatic logic [1:0] pick_cmd();
      int r;
      r = $urandom_range(0, 999);
      if (r < 12) return msns_pkg::CMD_START;
      if (r < 22) return msns_pkg::CMD_STOP;
      if (r < 28) return CMD_NONE;
      return msns_pkg::CMD_TICK;
   endfunction

   // hold until no result word is outstanding, then let an in-flight tick finish
   task automatic drain();
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic send_ticks(int n);
      repeat (n) send_word(make_word(msns_pkg::CMD_TICK));
   endtask

   initial begin : stimulus
      bit [23:0] w;
      int sent;
      sb = new();
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      repeat (9) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // directed: idle commands, overflow pick, wrap of note number
      write_reg(msns_pkg::REG_SCALE, 0);
      write_reg(msns_pkg::REG_RHYTHM, 0);
      write_reg(msns_pkg::REG_ROOT, 127);
      write_reg(msns_pkg::REG_TEMPO, 65535);
      send_word(make_word(msns_pkg::CMD_TICK));
      send_word(make_word(msns_pkg::CMD_STOP));
      send_word(make_word(CMD_NONE));
      send_word(make_word(msns_pkg::CMD_START));
      w = 24'h0; w[1:0] = msns_pkg::CMD_TICK; w[9:2] = 8'hFF; w[18:12] = 0; w[20:19] = 3;
      send_word(w);
      send_ticks(70);
      send_word(make_word(msns_pkg::CMD_START));
      send_ticks(2);
      send_word(make_word(msns_pkg::CMD_STOP));
      drain();
      write_reg(msns_pkg::REG_SCALE, 7);
      write_reg(msns_pkg::REG_RHYTHM, 3);
      write_reg(msns_pkg::REG_ROOT, 0);
      write_reg(msns_pkg::REG_TEMPO, 0);
      send_word(make_word(msns_pkg::CMD_START));
      w = 24'hFFFFFF; w[1:0] = msns_pkg::CMD_TICK; w[11:10] = 0; w[18:12] = 0;
      w[20:19] = 0;
      send_word(w);
      send_ticks(3);
      drain();

      // random phases over several settings
      sent = 0;
      for (int phase = 0; sent < 1750 || results_seen < 60; phase++) begin
         write_reg(msns_pkg::REG_SCALE, (phase < 2) ? 7 * phase : $urandom_range(0, 7));
         write_reg(msns_pkg::REG_RHYTHM, (phase < 4) ? phase : $urandom_range(0, 3));
         write_reg(msns_pkg::REG_ROOT,
                   (phase == 0) ? 0 : (phase == 1) ? 127 : $urandom_range(0, 127));
         write_reg(msns_pkg::REG_TEMPO, (phase == 2) ? 40 : (phase == 3) ? 65535 :
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) :
                   $urandom_range(200, 260));
         if (phase == 0 || $urandom_range(0, 1)) begin
            send_word(make_word(msns_pkg::CMD_START));
            sent++;
         end
         for (int i = 0; i < 250; i++) begin
            if (phase == 1 && i == 60) hold_request = 1;
            if (phase == 2 && i == 100) begin
               while (sb.expected_q.size() != 0) @(negedge clock);
            end
            send_word(make_word(pick_cmd()));
            sent++;
         end
         drain();
      end
      req_tvalid = 1'b0;
      drain();
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== markov_scale_note_sequencer_core.f =====
rtl/msns_pkg.sv
rtl/msns_divider.sv
rtl/markov_scale_note_sequencer_core.sv
rtl/msns_checker.sv
tb/tb.sv
